// File: rtl/apcf_pkg.sv
// Shared types and constants of the ADC piecewise calibration filter.
// Depends on nothing; every rtl file imports it.
package apcf_pkg;

	localparam int CODE_W         = 24;
	localparam int VAL_W          = 48;
	localparam int DIV_W          = 73;
	localparam int DIVR_W         = 24;
	localparam int CAL_POINTS_DEF = 16;
	localparam int AVG_LEN_DEF    = 16;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVER_CODE = 2'd1;
	localparam logic [1:0] ST_OVER_RNG  = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	localparam logic REG_MAX_CODE  = 1'b0;
	localparam logic REG_RANGE_MAX = 1'b1;

	localparam logic [50:0] QUOT_CAP = {1'b1, 50'd0};

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_REQ,
		S_SCAN_CHK,
		S_PAIR_REQ,
		S_PAIR_LO,
		S_PAIR_HI,
		S_MUL_LO,
		S_MUL_HI,
		S_MUL_SUM,
		S_DIV_INT,
		S_RING_RD,
		S_RING_UPD,
		S_DIV_AVG,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

// File: rtl/apcf_tab.sv
// Calibration point memory: one word holds the code and the value of a point.
// Depends on apcf_pkg.
module apcf_tab
	import apcf_pkg::*;
#(
	parameter int CAL_POINTS = CAL_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(CAL_POINTS)-1:0] waddr,
	input  logic [CODE_W+VAL_W-1:0]       wdata,
	input  logic [$clog2(CAL_POINTS)-1:0] raddr,
	output logic [CODE_W+VAL_W-1:0]       rdata
);

	logic [CODE_W+VAL_W-1:0] mem [CAL_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/apcf_ring.sv
// Moving-average sample ring: memory plus per-entry valid flags so that
// entries never written read as zero. Depends on apcf_pkg.
module apcf_ring
	import apcf_pkg::*;
#(
	parameter int AVERAGE_LENGTH = AVG_LEN_DEF,
	parameter int RPW = (AVERAGE_LENGTH > 1) ? $clog2(AVERAGE_LENGTH) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    we,
	input  logic [RPW-1:0]          waddr,
	input  logic signed [VAL_W-1:0] wdata,
	input  logic [RPW-1:0]          raddr,
	output logic signed [VAL_W-1:0] rdata
);

	logic [VAL_W-1:0]          mem [AVERAGE_LENGTH];
	logic [AVERAGE_LENGTH-1:0] valid_q;
	logic [VAL_W-1:0]          mem_rd_q;
	logic                      vld_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			vld_rd_q <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		mem_rd_q <= mem[raddr];
	end

	assign rdata = vld_rd_q ? $signed(mem_rd_q) : '0;

endmodule

// File: rtl/apcf_div.sv
// Restoring divider, one quotient bit per cycle, used for the interpolation
// quotient. Depends on apcf_pkg.
module apcf_div
	import apcf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CW = $clog2(DIV_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] dvs_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIVR_W:0]   trial;
	logic              take;

	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		take  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? DIVR_W'(trial - {1'b0, dvs_q}) : trial[DIVR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], take};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a run");

endmodule

// File: rtl/adc_piecewise_calibration_filter.sv
// Top level of the ADC piecewise calibration filter: sequencer, datapath
// and output register. Depends on apcf_pkg, apcf_tab, apcf_ring, apcf_div.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, command, sample_code,  | into block
//          | point_value                               |
//  out     | out_valid, out_stall, result_value, status | out of block
//  config  | wr_en, wr_index, wr_data                  | into block
//
// One word is in work at a time. A load or an over-code word goes from idle
// straight to the result state. A conversion is accepted and, with two or more
// points loaded, scans the table points (one read of the point memory each),
// reads the segment pair and, unless its codes are equal, does the two-part
// multiply and the interpolation divide; it then updates the ring, shifts the
// average and hands off. AVERAGE_LENGTH must be a power of two.
// Reset clears the point count, ring position, sum and ring valid flags at
// once; no clearing pass. The output register holds a finished word while
// out_stall is high; the next word is accepted meanwhile and parks in the
// result state until the output register frees.
module adc_piecewise_calibration_filter
	import apcf_pkg::*;
#(
	parameter int CAL_POINTS     = CAL_POINTS_DEF,
	parameter int AVERAGE_LENGTH = AVG_LEN_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    command,
	input  logic [CODE_W-1:0]       sample_code,
	input  logic signed [VAL_W-1:0] point_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VAL_W-1:0] result_value,
	output logic [1:0]              status,
	input  logic                    wr_en,
	input  logic                    wr_index,
	input  logic [VAL_W-1:0]        wr_data
);

	localparam int TIW    = $clog2(CAL_POINTS);
	localparam int TCW    = $clog2(CAL_POINTS + 1);
	localparam int RPW    = (AVERAGE_LENGTH > 1) ? $clog2(AVERAGE_LENGTH) : 1;
	localparam int SUM_W  = VAL_W + $clog2(AVERAGE_LENGTH) + 1;
	localparam int AVG_SH = $clog2(AVERAGE_LENGTH);

	state_t state_q, state_d;

	// configuration
	logic [CODE_W-1:0]       max_code_q;
	logic signed [VAL_W-1:0] range_max_q;

	// table bookkeeping
	logic [TCW-1:0]    cnt_q;
	logic [TIW-1:0]    scan_q;
	logic [TIW-1:0]    seg_q;
	logic [CODE_W-1:0] prev_q;

	// current word
	logic [CODE_W-1:0]       code_q;
	logic [CODE_W-1:0]       c1_q;
	logic signed [VAL_W-1:0] v1_q;
	logic [VAL_W:0]          a_q;
	logic [DIVR_W-1:0]       d_q;
	logic [CODE_W-1:0]       dx_q;
	logic                    neg_q;
	logic [48:0]             p_lo_q;
	logic [47:0]             p_hi_q;
	logic [DIV_W-1:0]        prod_q;
	logic signed [VAL_W-1:0] interp_q;
	logic                    div_run_q;

	// filter
	logic signed [SUM_W-1:0] sum_q;
	logic [RPW-1:0]          pos_q;

	// pending and output words
	logic signed [VAL_W-1:0] res_val_q;
	logic [1:0]              res_st_q;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_val_q;
	logic [1:0]              out_st_q;

	// submodule links
	logic                    tab_we;
	logic [TIW-1:0]          tab_raddr;
	logic [CODE_W+VAL_W-1:0] tab_rdata;
	logic [CODE_W-1:0]       rd_code;
	logic signed [VAL_W-1:0] rd_val;
	logic                    ring_we;
	logic signed [VAL_W-1:0] ring_rdata;
	div_req_t                div_req;
	div_rsp_t                div_rsp;

	logic                    in_acc;
	logic                    out_free;
	logic                    seg_hit;
	logic                    scan_last;

	// combinational datapath terms
	logic signed [VAL_W:0]   dv;
	logic signed [CODE_W:0]  dc;
	logic [CODE_W-1:0]       x_eff;
	logic [50:0]             q_cap;
	logic signed [51:0]      res_wide;
	logic signed [VAL_W-1:0] res_sat;
	logic signed [SUM_W-1:0] sum_new;
	logic [SUM_W-1:0]        sum_mag;
	logic [VAL_W-1:0]        avg_mag;
	logic signed [VAL_W-1:0] avg;

	assign rd_code   = tab_rdata[CODE_W+VAL_W-1:VAL_W];
	assign rd_val    = $signed(tab_rdata[VAL_W-1:0]);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign scan_last = scan_q == TIW'(cnt_q - 1'b1);

	always_comb begin
		if (scan_q == '0) begin
			seg_hit = code_q < rd_code;
		end else begin
			seg_hit = (code_q >= prev_q) && (code_q <= rd_code);
		end
	end

	// segment arithmetic, evaluated while the upper point is on the read port
	always_comb begin
		x_eff = (code_q < c1_q) ? c1_q : code_q;
		dv    = (VAL_W+1)'(rd_val) - (VAL_W+1)'(v1_q);
		dc    = $signed({1'b0, rd_code}) - $signed({1'b0, c1_q});
	end

	// interpolation result: cap the quotient, add it to or subtract it from the lower value, saturate
	always_comb begin
		q_cap    = (div_rsp.quotient > DIV_W'(QUOT_CAP)) ? QUOT_CAP
		           : div_rsp.quotient[50:0];
		res_wide = neg_q ? (52'(v1_q) - $signed({1'b0, q_cap}))
		                 : (52'(v1_q) + $signed({1'b0, q_cap}));
		if (res_wide[51:VAL_W-1] == '0 || res_wide[51:VAL_W-1] == '1) begin
			res_sat = res_wide[VAL_W-1:0];
		end else begin
			res_sat = res_wide[51] ? {1'b1, {(VAL_W-1){1'b0}}}
			                       : {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	// average: shift the magnitude of the sum, restore the sign (truncate to zero)
	always_comb begin
		sum_new = sum_q - SUM_W'(ring_rdata) + SUM_W'(interp_q);
		sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		avg_mag = VAL_W'(sum_mag >> AVG_SH);
		avg     = sum_q[SUM_W-1] ? -$signed(avg_mag) : $signed(avg_mag);
	end

	// sequencer: next state, memory addresses, divider launch
	always_comb begin
		state_d          = state_q;
		in_stall         = 1'b1;
		tab_raddr        = scan_q;
		tab_we           = 1'b0;
		ring_we          = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor  = d_q;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (command) begin
						tab_we  = cnt_q != TCW'(CAL_POINTS);
						state_d = S_RESULT;
					end else if (sample_code > max_code_q) begin
						state_d = S_RESULT;
					end else if (cnt_q < TCW'(2)) begin
						state_d = S_RING_RD;
					end else begin
						state_d = S_SCAN_REQ;
					end
				end
			end
			S_SCAN_REQ: begin
				state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				state_d = (seg_hit || scan_last) ? S_PAIR_REQ : S_SCAN_REQ;
			end
			S_PAIR_REQ: begin
				tab_raddr = seg_q - 1'b1;
				state_d   = S_PAIR_LO;
			end
			S_PAIR_LO: begin
				tab_raddr = seg_q;
				state_d   = S_PAIR_HI;
			end
			S_PAIR_HI: begin
				state_d = (rd_code == c1_q) ? S_RING_RD : S_MUL_LO;
			end
			S_MUL_LO: begin
				state_d = S_MUL_HI;
			end
			S_MUL_HI: begin
				state_d = S_MUL_SUM;
			end
			S_MUL_SUM: begin
				state_d = S_DIV_INT;
			end
			S_DIV_INT: begin
				// launch once on entry, then wait for the done pulse
				div_req.start = !div_rsp.busy && !div_run_q;
				if (div_rsp.done) begin
					state_d = S_RING_RD;
				end
			end
			S_RING_RD: begin
				state_d = S_RING_UPD;
			end
			S_RING_UPD: begin
				ring_we = 1'b1;
				state_d = S_DIV_AVG;
			end
			S_DIV_AVG: begin
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_code_q  <= {CODE_W{1'b1}};
			range_max_q <= {1'b0, {(VAL_W-1){1'b1}}};
			cnt_q       <= '0;
			sum_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			div_run_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_MAX_CODE:  max_code_q  <= wr_data[CODE_W-1:0];
					REG_RANGE_MAX: range_max_q <= $signed(wr_data);
					default: ;
				endcase
			end
			if (tab_we) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (ring_we) begin
				sum_q <= sum_new;
				pos_q <= (pos_q == RPW'(AVERAGE_LENGTH - 1)) ? '0 : pos_q + 1'b1;
			end
			if (div_rsp.done) begin
				div_run_q <= 1'b0;
			end else if (div_req.start) begin
				div_run_q <= 1'b1;
			end
			// drop the output word once taken, load the pending one when free
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				code_q    <= sample_code;
				scan_q    <= '0;
				interp_q  <= '0;
				res_val_q <= '0;
				if (command) begin
					res_st_q <= (cnt_q == TCW'(CAL_POINTS)) ? ST_FULL : ST_OK;
				end else begin
					res_st_q <= (sample_code > max_code_q) ? ST_OVER_CODE : ST_OK;
				end
			end
			S_SCAN_CHK: begin
				prev_q <= rd_code;
				if (seg_hit) begin
					seg_q <= (scan_q == '0) ? TIW'(1) : scan_q;
				end else if (scan_last) begin
					seg_q <= TIW'(cnt_q - 1'b1);
				end else begin
					scan_q <= scan_q + 1'b1;
				end
			end
			S_PAIR_LO: begin
				c1_q <= rd_code;
				v1_q <= rd_val;
			end
			S_PAIR_HI: begin
				interp_q <= rd_val;
				a_q      <= dv[VAL_W] ? (VAL_W+1)'(-dv) : (VAL_W+1)'(dv);
				d_q      <= dc[CODE_W] ? CODE_W'(-dc) : CODE_W'(dc);
				neg_q    <= dv[VAL_W] ^ dc[CODE_W];
				dx_q     <= x_eff - c1_q;
			end
			S_MUL_LO: begin
				p_lo_q <= 49'(a_q[24:0]) * 49'(dx_q);
			end
			S_MUL_HI: begin
				p_hi_q <= 48'(a_q[48:25]) * 48'(dx_q);
			end
			S_MUL_SUM: begin
				prod_q <= (DIV_W'(p_hi_q) << 25) + DIV_W'(p_lo_q);
			end
			S_DIV_INT: begin
				if (div_rsp.done) begin
					interp_q <= res_sat;
				end
			end
			S_DIV_AVG: begin
				if (avg > range_max_q) begin
					res_st_q  <= ST_OVER_RNG;
					res_val_q <= '0;
				end else begin
					res_st_q  <= ST_OK;
					res_val_q <= avg;
				end
			end
			S_RESULT: begin
				if (out_free) begin
					out_val_q <= res_val_q;
					out_st_q  <= res_st_q;
				end
			end
			default: ;
		endcase
	end

	apcf_tab #(
		.CAL_POINTS(CAL_POINTS)
	) u_tab (
		.clk  (clk),
		.we   (tab_we && in_acc),
		.waddr(TIW'(cnt_q)),
		.wdata({sample_code, point_value}),
		.raddr(tab_raddr),
		.rdata(tab_rdata)
	);

	apcf_ring #(
		.AVERAGE_LENGTH(AVERAGE_LENGTH),
		.RPW           (RPW)
	) u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (ring_we),
		.waddr (pos_q),
		.wdata (interp_q),
		.raddr (pos_q),
		.rdata (ring_rdata)
	);

	apcf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign out_valid    = out_valid_q;
	assign result_value = out_val_q;
	assign status       = out_st_q;

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("second word accepted while one is in work");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_st_q != ST_OK |-> out_val_q == '0)
		else $error("error word carries a nonzero value");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= TCW'(CAL_POINTS))
		else $error("point count beyond table depth");

	a_len_pow2: assert property (@(posedge clk)
		(AVERAGE_LENGTH & (AVERAGE_LENGTH - 1)) == 0)
		else $error("average length is not a power of two");

endmodule

// File: bench/apcf_tb_pkg.sv
// Command codes and value limits shared by the calibration filter bench.
// Depends on nothing; the checker and the bench top import it.
package apcf_tb_pkg;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic CMD_CONVERT = 1'b0;
	localparam logic CMD_LOAD    = 1'b1;

	localparam longint VAL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint VAL_MIN = -64'sh0000_8000_0000_0000;

endpackage

// File: bench/apcf_checker.sv
// Scoreboard of the calibration filter: predicts each result word from the
// accepted input words and register writes. Depends on apcf_pkg, apcf_tb_pkg.
module apcf_checker
	import apcf_pkg::*;
	import apcf_tb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic                    command,
	input  logic [CODE_W-1:0]       sample_code,
	input  logic signed [VAL_W-1:0] point_value,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic signed [VAL_W-1:0] result_value,
	input  logic [1:0]              status,
	input  logic                    wr_en,
	input  logic                    wr_index,
	input  logic [VAL_W-1:0]        wr_data,
	output int                      errors,
	output int                      pending
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS = CAL_POINTS_DEF;
	localparam int NAVG = AVG_LEN_DEF;

	typedef struct {
		longint     value;
		logic [1:0] st;
	} cal_word_t;

	cal_word_t  expected_words[$];
	logic [23:0] code_limit;
	longint      value_limit;
	logic [23:0] tab_code [NPTS];
	longint      tab_val [NPTS];
	int          tab_count;
	longint      ring [NAVG];
	longint      ring_sum;
	int          ring_pos;

	assign pending = expected_words.size();

	// Segment search: below the first point, first bracketing pair, else last pair.
	function automatic int pick_segment(logic [23:0] code);
		if (code < tab_code[0]) return 1;
		for (int i = 0; i + 1 < tab_count; i++)
			if (code >= tab_code[i] && code <= tab_code[i+1]) return i + 1;
		return tab_count - 1;
	endfunction

	function automatic longint interpolate(logic [23:0] code);
		int           k;
		longint       c1, c2, v1, v2, dv, dc, x, res;
		logic [127:0] a, d, dx, qa, ra, q, cap;
		bit           neg;
		if (tab_count < 2) return 0;
		k = pick_segment(code);
		c1 = tab_code[k-1];
		c2 = tab_code[k];
		v1 = tab_val[k-1];
		v2 = tab_val[k];
		if (c1 == c2) return v2;
		x = (code < c1) ? c1 : code;
		dv = v2 - v1;
		neg = dv < 0;
		a = neg ? -dv : dv;
		dc = c2 - c1;
		if (dc < 0) begin
			neg = !neg;
			d = -dc;
		end else begin
			d = dc;
		end
		dx = x - c1;
		cap = 128'd1 << 50;
		qa = a / d;
		ra = a % d;
		if (dx != 0 && qa > cap / dx) begin
			q = cap;
		end else begin
			q = qa * dx + (ra * dx) / d;
			if (q > cap) q = cap;
		end
		res = neg ? v1 - longint'(q) : v1 + longint'(q);
		if (res > VAL_MAX) res = VAL_MAX;
		if (res < VAL_MIN) res = VAL_MIN;
		return res;
	endfunction

	function automatic cal_word_t predict(logic cmd, logic [23:0] code, longint pval);
		cal_word_t w;
		longint    v, avg;
		w.value = 0;
		w.st = ST_OK;
		if (cmd == CMD_LOAD) begin
			if (tab_count >= NPTS) begin
				w.st = ST_FULL;
			end else begin
				tab_code[tab_count] = code;
				tab_val[tab_count] = pval;
				tab_count++;
			end
			return w;
		end
		if (code > code_limit) begin
			w.st = ST_OVER_CODE;
			return w;
		end
		v = interpolate(code);
		ring_sum = ring_sum - ring[ring_pos] + v;
		ring[ring_pos] = v;
		ring_pos = (ring_pos + 1) % NAVG;
		avg = ring_sum / NAVG;
		if (avg > value_limit) w.st = ST_OVER_RNG;
		else w.value = avg;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cal_word_t w;
		if (!arst_n) begin
			expected_words.delete();
			errors <= 0;
			code_limit = 24'hFFFFFF;
			value_limit = VAL_MAX;
			tab_count = 0;
			ring_sum = 0;
			ring_pos = 0;
			foreach (ring[i]) ring[i] = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word value=%0d status=%0d", $time,
						result_value, status);
					errors <= errors + 1;
				end else begin
					w = expected_words.pop_front();
					if (longint'(result_value) != w.value || status != w.st) begin
						$display("%0t: mismatch expected value=%0d status=%0d, got value=%0d status=%0d",
							$time, w.value, w.st, result_value, status);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_words.push_back(predict(command, sample_code, longint'(point_value)));
			if (wr_en) begin
				if (wr_index == REG_MAX_CODE) code_limit = wr_data[23:0];
				else value_limit = longint'($signed(wr_data));
			end
		end
	end

endmodule

// File: bench/tb_adc_piecewise_calibration_filter.sv
// Bench top of the calibration filter: clock, reset, stimulus and verdict.
// Depends on apcf_pkg, apcf_tb_pkg, apcf_checker and the block under test.
module tb_adc_piecewise_calibration_filter;
	import apcf_pkg::*;
	import apcf_tb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic                    command;
	logic [CODE_W-1:0]       sample_code;
	logic signed [VAL_W-1:0] point_value;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [VAL_W-1:0] result_value;
	logic [1:0]              status;
	logic                    wr_en;
	logic                    wr_index;
	logic [VAL_W-1:0]        wr_data;
	int                      errors;
	int                      pending;

	// Percent chances of a sender gap and of a receiver stall, per cycle.
	int idle_pct;
	int stall_pct;
	// Request for one long receiver hold-off; the receiver clears it.
	bit long_hold;
	int words_sent;
	int loads_sent;

	adc_piecewise_calibration_filter dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .sample_code(sample_code), .point_value(point_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_value(result_value), .status(status),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	apcf_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .sample_code(sample_code), .point_value(point_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_value(result_value), .status(status),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Generous cap: far above the slowest legal run.
	initial begin
		#100ms;
		$display("tb: failure");
		$finish;
	end

	// Receiver: random stalls, or one long hold-off on request so the block
	// fills up and stalls its input.
	initial begin
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				long_hold = 0;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Offer one word and hold it until it is accepted; valid stays up after.
	task automatic send_word(logic cmd, logic [23:0] code, longint val);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		sample_code <= code;
		point_value <= val[47:0];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
		if (cmd == CMD_LOAD) loads_sent++;
	endtask

	// Drain all results, then write one register while the block is idle.
	task automatic write_reg(logic idx, logic [47:0] data);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || out_valid) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	function automatic logic [23:0] pick_code();
		int sel;
		sel = $urandom_range(99);
		if (sel < 40) return 24'($urandom_range(24'hFFFFFF, 0));
		if (sel < 60) return 24'($urandom_range(63, 0));
		if (sel < 75) return 24'hFFFFFF - 24'($urandom_range(31, 0));
		return 24'(32'h100000 + $urandom_range(4095, 0) - 32'd2048);
	endfunction

	function automatic longint pick_value();
		longint v;
		v = {$urandom, $urandom};
		return longint'($signed(v[47:0]));
	endfunction

	initial begin
		logic [23:0] mc;
		longint      rm;
		idle_pct = 0;
		stall_pct = 0;
		long_hold = 0;
		words_sent = 0;
		loads_sent = 0;
		in_valid = 0;
		command = CMD_CONVERT;
		sample_code = 0;
		point_value = 0;
		wr_en = 0;
		wr_index = REG_MAX_CODE;
		wr_data = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty and one-point table convert to zero.
		send_word(CMD_CONVERT, 24'd500, 0);
		send_word(CMD_LOAD, 24'd1000, 5);
		send_word(CMD_CONVERT, 24'd0, 0);
		send_word(CMD_CONVERT, 24'd1000, 0);
		// First pair shares a code: below-first codes take the upper value.
		send_word(CMD_LOAD, 24'd1000, 64'sd100 <<< 16);
		send_word(CMD_CONVERT, 24'd0, 0);
		send_word(CMD_CONVERT, 24'hFFFFFF, 0);
		// Unsorted steep pair to force saturation, then fill the table.
		send_word(CMD_LOAD, 24'h000010, VAL_MAX);
		send_word(CMD_LOAD, 24'h000020, VAL_MIN);
		send_word(CMD_LOAD, 24'h100000, 12345);
		for (int i = 0; i < 9; i++)
			send_word(CMD_LOAD, 24'($urandom_range(24'hFFFFFF, 0)), pick_value());
		send_word(CMD_LOAD, 24'hFFFFF0, 64'sd1 <<< 40);
		send_word(CMD_LOAD, 24'hFFFFF8, -(64'sd1 <<< 40));
		send_word(CMD_LOAD, 24'hFFFFFF, VAL_MIN);
		send_word(CMD_CONVERT, 24'h000018, 0);
		send_word(CMD_CONVERT, 24'hFFFFFF, 0);
		send_word(CMD_CONVERT, 24'h100000, 0);
		// Over-code boundary and an over-range limit at the bottom.
		write_reg(REG_MAX_CODE, 48'h800000);
		send_word(CMD_CONVERT, 24'h800001, 0);
		send_word(CMD_CONVERT, 24'h800000, 0);
		write_reg(REG_RANGE_MAX, VAL_MIN[47:0]);
		send_word(CMD_CONVERT, 24'h000018, 0);
		send_word(CMD_CONVERT, 24'h000000, 0);

		// Random phases: rotate idling mode and register settings.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 76; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 76; end
				default: begin idle_pct = 6; stall_pct = 6; end
			endcase
			case (ph)
				0: begin mc = 24'hFFFFFF; rm = VAL_MAX; end
				1: begin mc = 24'd0; rm = 0; end
				2: begin mc = 24'($urandom_range(24'hFFFFFF, 0)); rm = pick_value(); end
				3: begin
					mc = 24'hFFFFFF;
					rm = longint'($urandom_range(1 << 20, 0)) - (1 << 19);
				end
				4: begin mc = 24'h7FFFFF; rm = VAL_MIN; end
				default: begin mc = 24'hFFFFFF; rm = pick_value() >>> 8; end
			endcase
			write_reg(REG_MAX_CODE, {24'd0, mc});
			write_reg(REG_RANGE_MAX, rm[47:0]);
			if (ph == 0) long_hold = 1;
			for (int i = 0; i < 172; i++) begin
				if ($urandom_range(99) < 8)
					send_word(CMD_LOAD, 24'($urandom_range(24'hFFFFFF, 0)), pick_value());
				else
					send_word(CMD_CONVERT, pick_code(), 0);
			end
		end
		in_valid <= 1'b0;
		stall_pct = 0;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Covered %0d words (%0d loads): empty, short and full tables,", words_sent,
			loads_sent);
		$display("over-code, over-range, saturation and four idling modes with a long hold-off.");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
